@@ rtl/core/pcsb_pkg.sv @@
`timescale 1ns / 1ps
package pcsb_pkg;

	localparam int BEAMS = 2048;
	localparam int BEAM_W = $clog2(BEAMS);
	localparam int CORDIC_STEPS = 17;
	localparam int SQRT_STEPS = 16;
	localparam int DIV_STEPS = 17;
	localparam int HALF_PI_FINE = 205887;
	localparam int ANGLE_LIM = 25736;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_W = $clog2(FIFO_DEPTH);
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int ENTRY_W = 33;

	localparam logic OP_BIN = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ANGLE_LOW,
		REG_ANGLE_HIGH,
		REG_ANGLE_STEP,
		REG_RANGE_LOW,
		REG_RANGE_HIGH,
		REG_INTENSITY_PRESENT,
		REG_FILTER_ENABLE,
		REG_INTENSITY_FLOOR
	} cfg_reg_t;

	typedef struct packed {
		logic               op;
		logic signed [15:0] x_mm;
		logic signed [15:0] y_mm;
		logic [15:0]        point_intensity;
		logic [10:0]        beam_select;
	} in_item_t;

	typedef struct packed {
		logic [10:0] beam_number;
		logic        beam_hit;
		logic [15:0] beam_range;
		logic [15:0] beam_intensity;
	} out_item_t;

	typedef struct packed {
		logic signed [15:0] angle_low;
		logic signed [15:0] angle_high;
		logic [13:0]        angle_step;
		logic [15:0]        range_low;
		logic [15:0]        range_high;
		logic               intensity_present;
		logic               filter_enable;
		logic [15:0]        intensity_floor;
	} cfg_t;

	// one classified job handed from the front to the back
	typedef struct packed {
		logic              read;
		logic              in_range;
		logic [10:0]       number;
		logic [BEAM_W-1:0] idx;
		logic [15:0]       range;
		logic [15:0]       inten;
	} job_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_MUL,
		F_SUM,
		F_ITER,
		F_CHECK,
		F_DIV,
		F_BOUND,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_CLEAR,
		B_IDLE,
		B_EXEC
	} back_state_t;

	// atan(2^-i) in units of 1/131072 rad
	function automatic logic [16:0] atan_fine(input logic [4:0] i);
		logic [16:0] v;
		case (i)
			5'd0: v = 17'd102944;
			5'd1: v = 17'd60771;
			5'd2: v = 17'd32110;
			5'd3: v = 17'd16299;
			5'd4: v = 17'd8181;
			5'd5: v = 17'd4095;
			5'd6: v = 17'd2048;
			5'd7: v = 17'd1024;
			5'd8: v = 17'd512;
			5'd9: v = 17'd256;
			5'd10: v = 17'd128;
			5'd11: v = 17'd64;
			5'd12: v = 17'd32;
			5'd13: v = 17'd16;
			5'd14: v = 17'd8;
			5'd15: v = 17'd4;
			5'd16: v = 17'd2;
			default: v = 17'd0;
		endcase
		return v;
	endfunction

endpackage

@@ rtl/core/point_cloud_to_scan_binner.sv @@
`timescale 1ns / 1ps
// channel  | direction | handshake                 | payload
// point    | in        | point_valid, point_stall  | in_item_t (op, x, y, intensity, beam)
// beam     | out       | beam_valid, beam_stall    | out_item_t (number, hit, range, intensity)
// cfg      | in        | cfg_write                 | cfg_index, cfg_data
// A bin item that passes the range, intensity and angle tests goes through the front
// as 17 CORDIC iterations (the first 16 also carry the square root), a 17-step
// restoring divider for the beam index, and a multiply for the beam bound; one dropped
// by those tests leaves the front after the iterations. A read item goes straight to
// the push state; the back does a read-modify-write of the beam store for each item
// (one RAM port pair). After reset the back clears the 2048-entry beam store, one entry
// a cycle; no item is accepted while it clears.
// A stalled result holds in the output register; the 4-entry queue lets the front go on.
module point_cloud_to_scan_binner import pcsb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  point_valid,
	output logic                  point_stall,
	input  in_item_t              point,
	output logic                  beam_valid,
	input  logic                  beam_stall,
	output out_item_t             beam,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t cfg_q;
	logic clearing;
	logic q_full, q_empty, q_push, q_pop;
	job_t q_job, q_head;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.angle_low <= -16'(ANGLE_LIM);
			cfg_q.angle_high <= 16'(ANGLE_LIM);
			cfg_q.angle_step <= 14'd41;
			cfg_q.range_low <= 16'd100;
			cfg_q.range_high <= 16'd10000;
			cfg_q.intensity_present <= 1'b1;
			cfg_q.filter_enable <= 1'b0;
			cfg_q.intensity_floor <= 16'd50;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_ANGLE_LOW: cfg_q.angle_low <= cfg_data;
				REG_ANGLE_HIGH: cfg_q.angle_high <= cfg_data;
				REG_ANGLE_STEP: cfg_q.angle_step <= cfg_data[13:0];
				REG_RANGE_LOW: cfg_q.range_low <= cfg_data;
				REG_RANGE_HIGH: cfg_q.range_high <= cfg_data;
				REG_INTENSITY_PRESENT: cfg_q.intensity_present <= cfg_data[0];
				REG_FILTER_ENABLE: cfg_q.filter_enable <= cfg_data[0];
				REG_INTENSITY_FLOOR: cfg_q.intensity_floor <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	pcsb_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.in_valid(point_valid),
		.in_stall(point_stall),
		.in_item (point),
		.clearing(clearing),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_job   (q_job)
	);

	pcsb_fifo u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_job(q_job),
		.pop     (q_pop),
		.head    (q_head),
		.full    (q_full),
		.empty   (q_empty)
	);

	pcsb_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (q_head),
		.empty    (q_empty),
		.pop      (q_pop),
		.clearing (clearing),
		.out_valid(beam_valid),
		.out_stall(beam_stall),
		.out_item (beam)
	);

endmodule

@@ rtl/core/pcsb_ram.sv @@
`timescale 1ns / 1ps
module pcsb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ rtl/core/pcsb_fifo.sv @@
`timescale 1ns / 1ps
module pcsb_fifo import pcsb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output job_t head,
	output logic full,
	output logic empty
);

	job_t              slot_q [FIFO_DEPTH];
	logic [FIFO_W-1:0] wr_ptr_q;
	logic [FIFO_W-1:0] rd_ptr_q;
	logic [FIFO_W:0]   count_q;

	assign full = (count_q == (FIFO_W+1)'(FIFO_DEPTH));
	assign empty = (count_q == '0);
	assign head = slot_q[rd_ptr_q];

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// store item slots
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

@@ rtl/core/pcsb_front.sv @@
`timescale 1ns / 1ps
module pcsb_front import pcsb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_item_t in_item,
	input  logic     clearing,
	input  logic     q_full,
	output logic     q_push,
	output job_t     q_job
);

	front_state_t state_q, state_n;

	logic               read_q;
	logic [10:0]        sel_q;
	logic signed [15:0] x_q, y_q;
	logic [15:0]        inten_q;
	logic [31:0]        xx_q, yy_q;
	logic [31:0]        rem_q, root_q;
	logic signed [35:0] cx_q, cy_q;
	logic signed [21:0] acc_q;
	logic               zero_q;
	logic [4:0]         cnt_q;
	logic [15:0]        range_q;
	logic [15:0]        inten_eff_q;
	logic [14:0]        drem_q;
	logic [16:0]        quo_q;
	logic [30:0]        prod_q;

	logic               accept;
	logic [31:0]        bitv, trial;
	logic signed [35:0] xs, ys;
	logic signed [35:0] px, py;
	logic signed [21:0] pacc;
	logic [15:0]        range_w;
	logic signed [23:0] tsum, tang;
	logic signed [15:0] angle_w;
	logic [16:0]        diff_w, offs_w;
	logic               drop_w;
	logic [14:0]        rdn;
	logic               keep_w;

	function automatic logic signed [35:0] shr_tz(input logic signed [35:0] v,
		input logic [4:0] s);
		logic signed [35:0] r;
		if (v < 0) begin
			r = -((-v) >>> s);
		end else begin
			r = v >>> s;
		end
		return r;
	endfunction

	assign accept = in_valid && !in_stall;

	// square root digit and CORDIC step
	assign bitv = 32'h4000_0000 >> {cnt_q, 1'b0};
	assign trial = root_q + bitv;
	assign xs = shr_tz(cx_q, cnt_q);
	assign ys = shr_tz(cy_q, cnt_q);

	// rotate into the right half plane
	always_comb begin
		px = 36'(x_q);
		py = 36'(y_q);
		pacc = '0;
		if (x_q < 0) begin
			if (y_q >= 0) begin
				px = 36'(y_q);
				py = -36'(x_q);
				pacc = 22'(HALF_PI_FINE);
			end else begin
				px = -36'(y_q);
				py = 36'(x_q);
				pacc = -22'(HALF_PI_FINE);
			end
		end
	end

	// round range and angle, then classify
	assign range_w = root_q[15:0] + 16'(rem_q > root_q);
	assign tsum = 24'(acc_q) + 24'sd1048584;
	assign tang = (tsum >>> 4) - 24'sd65536;
	always_comb begin
		if (zero_q) begin
			angle_w = '0;
		end else if (tang > 24'(ANGLE_LIM)) begin
			angle_w = 16'(ANGLE_LIM);
		end else if (tang < -24'(ANGLE_LIM)) begin
			angle_w = -16'(ANGLE_LIM);
		end else begin
			angle_w = tang[15:0];
		end
	end
	assign diff_w = 17'({cfg.angle_high[15], cfg.angle_high} -
		{cfg.angle_low[15], cfg.angle_low});
	assign offs_w = 17'({angle_w[15], angle_w} - {cfg.angle_low[15], cfg.angle_low});
	assign drop_w = (range_w < cfg.range_low) || (range_w > cfg.range_high) ||
		(cfg.intensity_present && cfg.filter_enable && (inten_q < cfg.intensity_floor)) ||
		(angle_w < cfg.angle_low) || (angle_w > cfg.angle_high) ||
		(cfg.angle_step == '0) || (cfg.angle_high <= cfg.angle_low);

	// restoring divide step and beam bound
	assign rdn = {drem_q[13:0], quo_q[16]};
	assign keep_w = (32'(quo_q) < BEAMS) && (prod_q < 31'(diff_w));

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			F_IDLE: begin
				if (accept) begin
					state_n = (in_item.op == OP_READ) ? F_PUSH : F_MUL;
				end
			end
			F_MUL: state_n = F_SUM;
			F_SUM: state_n = F_ITER;
			F_ITER: begin
				if (cnt_q == 5'(CORDIC_STEPS - 1)) begin
					state_n = F_CHECK;
				end
			end
			F_CHECK: state_n = drop_w ? F_IDLE : F_DIV;
			F_DIV: begin
				if (cnt_q == 5'(DIV_STEPS - 1)) begin
					state_n = F_BOUND;
				end
			end
			F_BOUND: state_n = F_PUSH;
			F_PUSH: begin
				if (!q_full) begin
					state_n = F_IDLE;
				end
			end
			default: state_n = F_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_stall = (state_q != F_IDLE) || clearing;
		q_push = (state_q == F_PUSH) && !q_full && (read_q || keep_w);
		q_job.read = read_q;
		q_job.in_range = read_q ? (32'(sel_q) < BEAMS) : 1'b1;
		q_job.number = sel_q;
		q_job.idx = read_q ? BEAM_W'(sel_q) : BEAM_W'(quo_q);
		q_job.range = range_q;
		q_job.inten = inten_eff_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				if (accept) begin
					read_q <= (in_item.op == OP_READ);
					sel_q <= in_item.beam_select;
					x_q <= in_item.x_mm;
					y_q <= in_item.y_mm;
					inten_q <= in_item.point_intensity;
				end
			end
			F_MUL: begin
				xx_q <= 32'(x_q) * 32'(x_q);
				yy_q <= 32'(y_q) * 32'(y_q);
			end
			F_SUM: begin
				rem_q <= xx_q + yy_q;
				root_q <= '0;
				cnt_q <= '0;
				cx_q <= px <<< 14;
				cy_q <= py <<< 14;
				acc_q <= pacc;
				zero_q <= (x_q == 0) && (y_q == 0);
			end
			F_ITER: begin
				if (cnt_q < 5'(SQRT_STEPS)) begin
					if (rem_q >= trial) begin
						rem_q <= rem_q - trial;
						root_q <= (root_q >> 1) + bitv;
					end else begin
						root_q <= root_q >> 1;
					end
				end
				if (cy_q >= 0) begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
					acc_q <= acc_q + $signed({5'b0, atan_fine(cnt_q)});
				end else begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
					acc_q <= acc_q - $signed({5'b0, atan_fine(cnt_q)});
				end
				cnt_q <= cnt_q + 1'b1;
			end
			F_CHECK: begin
				range_q <= range_w;
				inten_eff_q <= cfg.intensity_present ? inten_q : '0;
				drem_q <= '0;
				quo_q <= offs_w;
				cnt_q <= '0;
			end
			F_DIV: begin
				if (rdn >= {1'b0, cfg.angle_step}) begin
					drem_q <= rdn - {1'b0, cfg.angle_step};
					quo_q <= {quo_q[15:0], 1'b1};
				end else begin
					drem_q <= rdn;
					quo_q <= {quo_q[15:0], 1'b0};
				end
				cnt_q <= cnt_q + 1'b1;
			end
			F_BOUND: begin
				prod_q <= 31'(quo_q) * 31'(cfg.angle_step);
			end
			default: begin
			end
		endcase
	end

endmodule

@@ rtl/core/pcsb_back.sv @@
`timescale 1ns / 1ps
module pcsb_back import pcsb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  job_t      head,
	input  logic      empty,
	output logic      pop,
	output logic      clearing,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item
);

	back_state_t state_q, state_n;

	logic [BEAM_W:0]      clr_q;
	job_t                 job_q;
	logic                 out_valid_q;
	out_item_t            out_q;

	logic                 wr_en;
	logic [BEAM_W-1:0]    wr_addr;
	logic [ENTRY_W-1:0]   wr_data;
	logic [ENTRY_W-1:0]   rd_data;
	logic                 occ;
	logic [15:0]          old_range;
	logic [15:0]          old_inten;
	logic                 slot_free;
	logic                 done;

	assign occ = rd_data[ENTRY_W-1];
	assign old_range = rd_data[31:16];
	assign old_inten = rd_data[15:0];
	assign slot_free = !out_valid_q || !out_stall;
	assign done = (state_q == B_EXEC) && (!job_q.read || slot_free);

	pcsb_ram #(.WIDTH(ENTRY_W), .DEPTH(BEAMS)) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (pop),
		.rd_addr(head.idx),
		.rd_data(rd_data)
	);

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			B_CLEAR: begin
				if (clr_q[BEAM_W-1:0] == BEAM_W'(BEAMS - 1)) begin
					state_n = B_IDLE;
				end
			end
			B_IDLE: begin
				if (!empty) begin
					state_n = B_EXEC;
				end
			end
			B_EXEC: begin
				if (done) begin
					state_n = B_IDLE;
				end
			end
			default: state_n = B_IDLE;
		endcase
	end

	// outputs and store write
	always_comb begin
		clearing = (state_q == B_CLEAR);
		pop = (state_q == B_IDLE) && !empty;
		wr_en = 1'b0;
		wr_addr = job_q.idx;
		wr_data = '0;
		case (state_q)
			B_CLEAR: begin
				wr_en = 1'b1;
				wr_addr = clr_q[BEAM_W-1:0];
			end
			B_EXEC: begin
				if (job_q.read) begin
					wr_en = done && job_q.in_range;
				end else begin
					wr_en = !occ || (job_q.range < old_range);
					wr_data = {1'b1, job_q.range, job_q.inten};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_CLEAR;
			clr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == B_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			// hold result until taken
			if (done && job_q.read) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head;
		end
		if (done && job_q.read) begin
			out_q.beam_number <= job_q.number;
			out_q.beam_hit <= job_q.in_range && occ;
			out_q.beam_range <= (job_q.in_range && occ) ? old_range : '0;
			out_q.beam_intensity <= (job_q.in_range && occ) ? old_inten : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_q;

endmodule

@@ test/beam_scan_checker.sv @@
`timescale 1ns / 1ps
module beam_scan_checker import pcsb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  point_valid,
	input  logic                  point_stall,
	input  in_item_t              point,
	input  logic                  beam_valid,
	input  logic                  beam_stall,
	input  out_item_t             beam,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    errors,
	output int                    pending,
	output logic [BEAMS-1:0]      known
);

	// atan(2^-i) in units of 1/131072 rad
	localparam longint ATAN_STEP [CORDIC_STEPS] = '{
		102944, 60771, 32110, 16299, 8181, 4095, 2048, 1024, 512,
		256, 128, 64, 32, 16, 8, 4, 2
	};

	cfg_t        regs;
	logic [15:0] near_range [BEAMS];
	logic [15:0] near_inten [BEAMS];
	logic        occupied [BEAMS];
	out_item_t   expected_beams [$];

	// nearest-millimetre square root
	function automatic longint unsigned round_root(input longint unsigned s);
		longint unsigned r, b, rem;
		r = 0;
		b = 64'd1 << 32;
		rem = s;
		while (b > s) b = b >> 2;
		while (b != 0) begin
			if (rem >= r + b) begin
				rem = rem - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		if (s - r * r > r) r++;
		return r;
	endfunction

	// vectoring CORDIC angle in 1/8192 rad
	function automatic int point_angle(input int yi, input int xi);
		longint x, y, acc, t, xs, ys, d;
		x = xi;
		y = yi;
		acc = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; acc = HALF_PI_FINE;
			end else begin
				t = x; x = -y; y = t; acc = -HALF_PI_FINE;
			end
		end
		x = x * 16384;
		y = y * 16384;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			d = longint'(1) << i;
			xs = x / d;
			ys = y / d;
			if (y >= 0) begin
				x = x + ys; y = y - xs; acc = acc + ATAN_STEP[i];
			end else begin
				x = x - ys; y = y + xs; acc = acc - ATAN_STEP[i];
			end
		end
		t = (acc + 8 + 1048576) / 16 - 65536;
		if (t > ANGLE_LIM) t = ANGLE_LIM;
		if (t < -ANGLE_LIM) t = -ANGLE_LIM;
		return int'(t);
	endfunction

	// fold one point into its beam, if it survives every filter
	function automatic void bin_point(input in_item_t p);
		int x, y, ang, diff, step, count, idx;
		longint unsigned rng;
		logic [15:0] inten;
		x = p.x_mm;
		y = p.y_mm;
		inten = p.point_intensity;
		rng = round_root(longint'(x * x) + longint'(y * y));
		if (rng < regs.range_low || rng > regs.range_high) return;
		if (regs.intensity_present && regs.filter_enable && inten < regs.intensity_floor)
			return;
		if (!regs.intensity_present) inten = '0;
		ang = point_angle(y, x);
		if (ang < int'(regs.angle_low) || ang > int'(regs.angle_high)) return;
		step = int'(regs.angle_step);
		if (step == 0) return;
		diff = int'(regs.angle_high) - int'(regs.angle_low);
		if (diff <= 0) return;
		count = (diff + step - 1) / step;
		if (count > BEAMS) count = BEAMS;
		idx = (ang - int'(regs.angle_low)) / step;
		if (idx >= count) return;
		if (!occupied[idx] || rng < near_range[idx]) begin
			occupied[idx] = 1'b1;
			near_range[idx] = rng[15:0];
			near_inten[idx] = inten;
		end
		known[idx] = 1'b1;
	endfunction

	// report one beam and clear it
	function automatic out_item_t read_beam(input logic [10:0] sel);
		out_item_t r;
		r = '0;
		r.beam_number = sel;
		if (sel < BEAMS) begin
			if (occupied[sel]) begin
				r.beam_hit = 1'b1;
				r.beam_range = near_range[sel];
				r.beam_intensity = near_inten[sel];
			end
			occupied[sel] = 1'b0;
			near_range[sel] = '0;
			near_inten[sel] = '0;
			known[sel] = 1'b1;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			regs.angle_low = -16'sd25736;
			regs.angle_high = 16'sd25736;
			regs.angle_step = 14'd41;
			regs.range_low = 16'd100;
			regs.range_high = 16'd10000;
			regs.intensity_present = 1'b1;
			regs.filter_enable = 1'b0;
			regs.intensity_floor = 16'd50;
			for (int i = 0; i < BEAMS; i++) begin
				occupied[i] = 1'b0;
				near_range[i] = '0;
				near_inten[i] = '0;
			end
			known = '0;
			expected_beams.delete();
			pending = 0;
			errors = 0;
		end else begin
			// track register writes
			if (cfg_write) begin
				case (cfg_reg_t'(cfg_index))
					REG_ANGLE_LOW: regs.angle_low = cfg_data;
					REG_ANGLE_HIGH: regs.angle_high = cfg_data;
					REG_ANGLE_STEP: regs.angle_step = cfg_data[13:0];
					REG_RANGE_LOW: regs.range_low = cfg_data;
					REG_RANGE_HIGH: regs.range_high = cfg_data;
					REG_INTENSITY_PRESENT: regs.intensity_present = cfg_data[0];
					REG_FILTER_ENABLE: regs.filter_enable = cfg_data[0];
					REG_INTENSITY_FLOOR: regs.intensity_floor = cfg_data;
					default: ;
				endcase
			end
			// compare an accepted beam against the oldest expectation
			if (beam_valid && !beam_stall) begin
				if (expected_beams.size() == 0) begin
					errors++;
					$display("%0t: unexpected beam item, actual %p", $time, beam);
				end else begin
					want = expected_beams.pop_front();
					if (want.beam_number !== beam.beam_number ||
					    want.beam_hit !== beam.beam_hit ||
					    want.beam_range !== beam.beam_range ||
					    want.beam_intensity !== beam.beam_intensity) begin
						errors++;
						$display("%0t: beam mismatch, expected %p, actual %p",
							$time, want, beam);
					end
				end
			end
			// predict from an accepted point item
			if (point_valid && !point_stall) begin
				if (point.op == OP_READ)
					expected_beams.insert(expected_beams.size(),
						read_beam(point.beam_select));
				else
					bin_point(point);
			end
			pending = expected_beams.size();
		end
	end

endmodule

@@ test/tb_point_cloud_to_scan_binner.sv @@
`timescale 1ns / 1ps
module tb_point_cloud_to_scan_binner;
	import pcsb_pkg::*;

	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 80;
	localparam int HOLD_CYCLES = 300;

	logic                  clk;
	logic                  arst_n;
	logic                  point_valid;
	logic                  point_stall;
	in_item_t              point;
	logic                  beam_valid;
	logic                  beam_stall;
	out_item_t             beam;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    errors;
	int                    pending;
	logic [BEAMS-1:0]      known;
	int                    idle_mode;
	logic                  hold_req;
	int                    quiet_cycles;

	point_cloud_to_scan_binner u_dut (
		.clk(clk), .arst_n(arst_n),
		.point_valid(point_valid), .point_stall(point_stall), .point(point),
		.beam_valid(beam_valid), .beam_stall(beam_stall), .beam(beam),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	beam_scan_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.point_valid(point_valid), .point_stall(point_stall), .point(point),
		.beam_valid(beam_valid), .beam_stall(beam_stall), .beam(beam),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending), .known(known)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// stall the beam channel per idle mode, or hold off for a long stretch
	initial begin
		beam_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				for (int i = 0; i < HOLD_CYCLES; i++) begin
					beam_stall = 1'b1;
					@(negedge clk);
				end
				hold_req = 1'b0;
			end
			beam_stall = (idle_mode == 2 || idle_mode == 3) ?
				($urandom_range(99) < (idle_mode == 2 ? 61 : 32)) : 1'b0;
		end
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((point_valid && !point_stall) || (beam_valid && !beam_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [15:0] v);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data = v;
		@(negedge clk);
		cfg_write = 1'b0;
	endtask

	task automatic set_regs(input int alo, input int ahi, input int step, input int rlo,
		input int rhi, input int present, input int filt, input int floor_v);
		write_reg(REG_ANGLE_LOW, alo[15:0]);
		write_reg(REG_ANGLE_HIGH, ahi[15:0]);
		write_reg(REG_ANGLE_STEP, step[15:0]);
		write_reg(REG_RANGE_LOW, rlo[15:0]);
		write_reg(REG_RANGE_HIGH, rhi[15:0]);
		write_reg(REG_INTENSITY_PRESENT, present[15:0]);
		write_reg(REG_FILTER_ENABLE, filt[15:0]);
		write_reg(REG_INTENSITY_FLOOR, floor_v[15:0]);
	endtask

	// offer one item; called and returns at a falling edge
	task automatic send_item(input in_item_t item);
		int idle_pct;
		idle_pct = (idle_mode == 1) ? 61 : (idle_mode == 3) ? 32 : 0;
		while ($urandom_range(99) < idle_pct) begin
			point_valid = 1'b0;
			@(negedge clk);
		end
		point_valid = 1'b1;
		point = item;
		do @(posedge clk); while (point_stall);
		@(negedge clk);
	endtask

	function automatic in_item_t make_bin(input int x, input int y, input int inten);
		in_item_t p;
		p.op = OP_BIN;
		p.x_mm = x[15:0];
		p.y_mm = y[15:0];
		p.point_intensity = inten[15:0];
		p.beam_select = 11'($urandom);
		return p;
	endfunction

	// read a beam the block has already written; fall back to a bin when none
	function automatic in_item_t make_read();
		in_item_t p;
		int start, idx;
		p = make_bin($urandom, $urandom, $urandom);
		start = $urandom_range(BEAMS - 1);
		for (int i = 0; i < BEAMS; i++) begin
			idx = (start + i) % BEAMS;
			if (known[idx]) begin
				p.op = OP_READ;
				p.beam_select = 11'(idx);
				return p;
			end
		end
		return p;
	endfunction

	function automatic in_item_t make_random();
		int cls, x, y, inten;
		if ($urandom_range(99) < 25) return make_read();
		cls = $urandom_range(99);
		if (cls < 25) begin
			x = $signed(16'($urandom));
			y = $signed(16'($urandom));
		end else if (cls < 80) begin
			x = $urandom_range(24000) - 12000;
			y = $urandom_range(24000) - 12000;
		end else begin
			x = $urandom_range(400) - 200;
			y = $urandom_range(400) - 200;
		end
		case ($urandom_range(3))
			0: inten = 0;
			1: inten = 65535;
			default: inten = $urandom_range(65535);
		endcase
		return make_bin(x, y, inten);
	endfunction

	// wait for every result, then let the pipeline empty
	task automatic drain();
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic run_random(input int count, input logic squeeze);
		for (int i = 0; i < count; i++) begin
			if (squeeze && i == count / 2) begin
				hold_req = 1'b1;
				for (int k = 0; k < 24; k++) send_item(make_read());
			end
			send_item(make_random());
		end
		point_valid = 1'b0;
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		point_valid = 1'b0;
		point = '0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		idle_mode = 0;
		hold_req = 1'b0;
		quiet_cycles = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: field extremes, zero point, quadrant edges, empty beam read
		set_regs(-25736, 25736, 41, 0, 46341, 1, 1, 50);
		send_item(make_bin(32767, 32767, 65535));
		send_item(make_bin(-32768, -32768, 0));
		send_item(make_bin(-32768, 0, 100));
		send_item(make_bin(0, 0, 200));
		send_item(make_bin(0, -5000, 300));
		send_item(make_bin(0, 5000, 49));
		send_item(make_bin(-100, 1, 400));
		send_item(make_bin(-100, -1, 500));
		send_item(make_bin(32767, -32768, 600));
		send_item(make_bin(3000, 0, 700));
		send_item(make_bin(2000, 0, 800));
		send_item(make_bin(2000, 0, 900));
		for (int i = 0; i < 8; i++) send_item(make_read());
		for (int i = 0; i < 3; i++) send_item(make_read());
		point_valid = 1'b0;
		drain();

		// random phases over several register settings and idle modes
		idle_mode = 0;
		set_regs(-25736, 25736, 8192, 100, 10000, 1, 0, 50);
		run_random(150, 1'b1);
		idle_mode = 1;
		set_regs(-1024, 1023, 1, 0, 46341, 1, 1, 65535);
		run_random(150, 1'b0);
		idle_mode = 2;
		set_regs(-25736, 25736, 41, 0, 46341, 0, 1, 65535);
		run_random(150, 1'b0);
		idle_mode = 3;
		set_regs(0, 8192, 3000, 500, 20000, 1, 1, 32768);
		run_random(150, 1'b0);
		idle_mode = 1;
		set_regs(25736, -25736, 41, 0, 46341, 1, 0, 0);
		run_random(100, 1'b0);
		idle_mode = 2;
		set_regs(-25736, 25736, 0, 0, 46341, 1, 0, 0);
		run_random(100, 1'b0);
		idle_mode = 0;
		set_regs(-8192, 8192, 1024, 46341, 46341, 1, 0, 0);
		run_random(50, 1'b0);
		idle_mode = 3;
		set_regs(-25736, 25736, 4000, 100, 15000, 1, 0, 50);
		run_random(200, 1'b0);

		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
